>>> rtl/wel_pkg.sv
package wel_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MODE       = 3'd0,
        REG_BATCH      = 3'd1,
        REG_NORM       = 3'd2,
        REG_GRAD_SCALE = 3'd3,
        REG_PROP_PRED  = 3'd4,
        REG_PROP_LABEL = 3'd5
    } cfg_idx_t;

    // Loss modes.
    typedef enum logic [2:0] {
        MODE_PLAIN     = 3'd0,
        MODE_NORM      = 3'd1,
        MODE_NORM_WGT  = 3'd2,
        MODE_WGT       = 3'd3,
        MODE_INTENSITY = 3'd4
    } mode_t;

    localparam int WEIGHTS       = 6;
    localparam int MAX_WEIGHT_IX = WEIGHTS - 1;
    localparam logic signed [15:0] MISSING_LABEL = 16'sd7373;
    localparam logic [15:0] ONE_Q412  = 16'd4096;
    localparam logic [15:0] ONE_Q88   = 16'd256;
    localparam int DIV_BITS = 64;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_ROUND_W,
        ST_MUL_SQ,
        ST_ACCUM,
        ST_DIV_G,
        ST_RND_G,
        ST_DIV_L,
        ST_RND_L,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul_w;
        logic round_w;
        logic mul_sq;
        logic accum;
        logic div_start_g;
        logic div_start_l;
        logic div_step;
        logic rnd_g;
        logic rnd_l;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic last;
        logic out_free;
    } status_t;

endpackage

>>> rtl/weighted_euclidean_loss_core.sv
// Weighted Euclidean loss core. Each input transfer carries a Q4.12
// prediction/label pair and six Q4.12 weights; every transfer yields one
// result transfer with the two saturated Q4.12 gradients and, on the transfer
// marked by s_tlast, the Q16.16 loss of the pass (m_tuser high). The core
// takes no new input transfer until the result of the current one has
// entered the output register; on the last item of a pass the loss division
// runs before that. The gradient and the loss go through one shared
// restoring divider that retires one quotient bit of a 64-bit dividend per
// cycle. The output register lets the next item be taken while a result
// still waits.
// Configuration registers must be written through cfg_we/cfg_addr/cfg_wdata
// only while the core is idle; the core itself does not enforce this.
module weighted_euclidean_loss_core #(
    parameter int INTENSITY_LEVELS = 6
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pred, label, weight0, weight1, weight2, weight3, weight4, weight5
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // grad_pred, grad_label, loss
    output logic [63:0]  m_tdata,
    // loss_valid
    output logic         m_tuser
);
    import wel_pkg::*;

    cmd_t    cmd;
    status_t status;

    wel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wel_datapath #(
        .INTENSITY_LEVELS (INTENSITY_LEVELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_flag  (m_tuser)
    );

endmodule

>>> rtl/wel_ctrl.sv
module wel_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  wel_pkg::status_t  status,
    output wel_pkg::cmd_t     cmd
);
    import wel_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_MUL_W;
            ST_MUL_W:   state_next = ST_ROUND_W;
            ST_ROUND_W: state_next = ST_MUL_SQ;
            ST_MUL_SQ:  state_next = ST_ACCUM;
            ST_ACCUM:   state_next = ST_DIV_G;
            ST_DIV_G:   if (status.div_done) state_next = ST_RND_G;
            ST_RND_G:   state_next = status.last ? ST_DIV_L : ST_EMIT;
            ST_DIV_L:   if (status.div_done) state_next = ST_RND_L;
            ST_RND_L:   state_next = ST_EMIT;
            ST_EMIT:    if (status.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL_W:   cmd.mul_w = 1'b1;
            ST_ROUND_W: cmd.round_w = 1'b1;
            ST_MUL_SQ:  cmd.mul_sq = 1'b1;
            ST_ACCUM: begin
                cmd.accum       = 1'b1;
                cmd.div_start_g = 1'b1;
            end
            ST_DIV_G:   cmd.div_step = !status.div_done;
            ST_RND_G: begin
                cmd.rnd_g       = 1'b1;
                cmd.div_start_l = status.last;
            end
            ST_DIV_L:   cmd.div_step = !status.div_done;
            ST_RND_L:   cmd.rnd_l = 1'b1;
            ST_EMIT:    cmd.emit = status.out_free;
            default: ;
        endcase
    end

endmodule

>>> rtl/wel_datapath.sv
module wel_datapath #(
    parameter int INTENSITY_LEVELS = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic [127:0]      in_data,
    input  logic              in_last,
    input  wel_pkg::cmd_t     cmd,
    output wel_pkg::status_t  status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_data,
    output logic              out_flag
);
    import wel_pkg::*;

    localparam int LIM = (INTENSITY_LEVELS - 1 > MAX_WEIGHT_IX) ? MAX_WEIGHT_IX
                                                                : INTENSITY_LEVELS - 1;

    // Configuration registers.
    logic [2:0]         mode_reg;
    logic [15:0]        batch_reg, norm_reg;
    logic signed [15:0] gscale_reg;
    logic               prop_pred_reg, prop_label_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_PLAIN;
            batch_reg      <= 16'd1;
            norm_reg       <= ONE_Q88;
            gscale_reg     <= ONE_Q412;
            prop_pred_reg  <= 1'b1;
            prop_label_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MODE:       mode_reg       <= cfg_wdata[2:0];
                REG_BATCH:      batch_reg      <= cfg_wdata;
                REG_NORM:       norm_reg       <= cfg_wdata;
                REG_GRAD_SCALE: gscale_reg     <= cfg_wdata;
                REG_PROP_PRED:  prop_pred_reg  <= cfg_wdata[0];
                REG_PROP_LABEL: prop_label_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Captured input transfer.
    logic signed [15:0] pred_reg, label_reg;
    logic [15:0]        w_reg [WEIGHTS];
    logic               last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pred_reg  <= in_data[15:0];
            label_reg <= in_data[31:16];
            for (int i = 0; i < WEIGHTS; i++) begin
                w_reg[i] <= in_data[32 + 16*i +: 16];
            end
            last_reg  <= in_last;
        end
    end

    // Weight selection and the weighted difference product.
    logic               use_norm, missing;
    logic [19:0]        lab_scaled;
    logic [7:0]         idx_raw;
    logic [2:0]         idx;
    logic [15:0]        weight, nv, batch;
    logic signed [16:0] diff;

    always_comb begin
        use_norm   = (mode_reg == MODE_NORM) || (mode_reg == MODE_NORM_WGT);
        nv         = use_norm ? ((norm_reg == '0) ? 16'd1 : norm_reg) : ONE_Q88;
        batch      = (batch_reg == '0) ? 16'd1 : batch_reg;
        diff       = 17'(pred_reg) - 17'(label_reg);
        lab_scaled = 20'(label_reg[14:0]) * 20'(INTENSITY_LEVELS - 1);
        idx_raw    = 8'((lab_scaled + 20'd2048) >> 12);
        if (label_reg <= 16'sd0) begin
            idx_raw = '0;
        end
        idx        = (idx_raw > 8'(LIM)) ? 3'(LIM) : idx_raw[2:0];
        missing    = (mode_reg == MODE_INTENSITY) && (label_reg == MISSING_LABEL);
        case (mode_reg)
            MODE_NORM_WGT, MODE_WGT: weight = w_reg[0];
            MODE_INTENSITY:          weight = w_reg[idx];
            default:                 weight = ONE_Q412;
        endcase
    end

    logic signed [33:0] p_reg;
    logic [31:0]        den_reg;
    logic               miss_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_w) begin
            p_reg    <= 34'(diff) * $signed({18'd0, weight});
            den_reg  <= 32'(batch) * 32'(nv);
            miss_reg <= missing;
        end
    end

    // Round the weighted difference to Q4.12, half away from zero.
    logic [31:0] p_mag;
    logic [20:0] wd_mag_reg;
    logic        wd_neg_reg;

    assign p_mag = p_reg[33] ? 32'(-p_reg) : p_reg[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.round_w) begin
            wd_mag_reg <= miss_reg ? '0 : 21'((33'(p_mag) + 33'd2048) >> 12);
            wd_neg_reg <= p_reg[33];
        end
    end

    // Square for the sum and gradient numerator.
    logic [15:0] gs_mag;
    logic [41:0] sq_reg;
    logic [36:0] prod_reg;
    logic        prod_neg_reg;

    assign gs_mag = gscale_reg[15] ? 16'(-gscale_reg) : gscale_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_sq) begin
            sq_reg       <= 42'(wd_mag_reg) * 42'(wd_mag_reg);
            prod_reg     <= 37'(gs_mag) * 37'(wd_mag_reg);
            prod_neg_reg <= gscale_reg[15] ^ wd_neg_reg;
        end
    end

    // Saturating running sum of squares.
    logic [63:0] sum_reg;
    logic [64:0] sum_add;

    assign sum_add = 65'(sum_reg) + 65'(sq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cmd.rnd_l) begin
            sum_reg <= '0;
        end else if (cmd.accum) begin
            sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [63:0] q_reg;
    logic [35:0] rem_reg, dvs_reg;
    logic [6:0]  cnt_reg;
    logic [36:0] rem_sh, rem_sub;
    logic        rem_ge, rnd_up;
    logic [64:0] q_rnd;

    assign rem_sh  = {rem_reg, q_reg[63]};
    assign rem_sub = rem_sh - 37'(dvs_reg);
    assign rem_ge  = rem_sh >= 37'(dvs_reg);
    assign rnd_up  = {1'b0, rem_reg, 1'b0} >= 38'(dvs_reg);
    assign q_rnd   = 65'(q_reg) + 65'(rnd_up);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start_g || cmd.div_start_l) begin
            cnt_reg <= 7'(DIV_BITS);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start_g) begin
            q_reg   <= 64'(prod_reg);
            rem_reg <= '0;
            dvs_reg <= {den_reg, 4'd0};
        end else if (cmd.div_start_l) begin
            q_reg   <= sum_reg;
            rem_reg <= '0;
            dvs_reg <= {3'd0, den_reg, 1'b0};
        end else if (cmd.div_step) begin
            q_reg   <= {q_reg[62:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[35:0] : rem_sh[35:0];
        end
    end

    // Gradient and loss results with saturation.
    function automatic logic [15:0] sat_grad(input logic neg, input logic [64:0] m);
        logic [15:0] r;
        if (!neg) begin
            r = (m > 65'd32767) ? 16'h7FFF : m[15:0];
        end else begin
            r = (m >= 65'd32768) ? 16'h8000 : 16'(-m[15:0]);
        end
        return r;
    endfunction

    logic [15:0] gp_reg, gl_reg;
    logic [31:0] loss_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rnd_g) begin
            gp_reg   <= prop_pred_reg  ? sat_grad(prod_neg_reg, q_rnd)  : '0;
            gl_reg   <= prop_label_reg ? sat_grad(!prod_neg_reg, q_rnd) : '0;
            loss_reg <= '0;
        end else if (cmd.rnd_l) begin
            loss_reg <= (q_rnd > 65'hFFFF_FFFF) ? '1 : q_rnd[31:0];
        end
    end

    // Output register.
    logic        ovalid_reg;
    logic [63:0] odata_reg;
    logic        oflag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            odata_reg <= {loss_reg, gl_reg, gp_reg};
            oflag_reg <= last_reg;
        end
    end

    assign out_valid       = ovalid_reg;
    assign out_data        = odata_reg;
    assign out_flag        = oflag_reg;
    assign status.div_done = (cnt_reg == '0);
    assign status.last     = last_reg;
    assign status.out_free = !ovalid_reg || out_ready;

endmodule

>>> rtl/wel_checker.sv
module wel_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic         m_tuser
);

    // A held result stays offered until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The core works on one item at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // The loss field is zero on every result that does not close a pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[63:32] == 32'd0)
        else $error("loss set outside a pass end");

    // An input transfer never produces a result in the very next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind weighted_euclidean_loss_core wel_checker u_wel_checker (.*);
